### src/rhh_pkg.sv
// Shared types, constants and the divider step function for the RGB to HSV/HSL converter.
package rhh_pkg;

    localparam int CHANNEL_BITS    = 8;
    localparam int LEVEL_BITS      = CHANNEL_BITS + 1;
    localparam int ALPHA_BITS      = 8;
    localparam int HUE_BITS        = 15;
    localparam int SAT_BITS        = 16;
    localparam int SAT_FRAC        = 16;

    // Each quotient is formed by a long division over DIV_W numerator bits.
    localparam int DIV_BITS        = CHANNEL_BITS + SAT_FRAC;
    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES      = (DIV_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DIV_W           = DIV_STAGES * STEPS_PER_STAGE;

    // Front stage, divider stages, output stage.
    localparam int LATENCY         = DIV_STAGES + 2;

    localparam logic [CHANNEL_BITS-1:0] FULL_SCALE   = '1;
    localparam logic [HUE_BITS-1:0]     SECTOR_UNITS = 15'd3840;
    localparam logic [HUE_BITS-1:0]     GREEN_OFFSET = 15'd7680;
    localparam logic [HUE_BITS-1:0]     BLUE_OFFSET  = 15'd15360;
    localparam logic [HUE_BITS-1:0]     FULL_CIRCLE  = 15'd23040;

    typedef enum logic {
        MODE_HSV = 1'b0,
        MODE_HSL = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef logic [CHANNEL_BITS-1:0] t_chan;

    // Partial remainder and the numerator shift register; quotient bits enter at the bottom.
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] rem;
        logic [DIV_W-1:0]        num;
    } t_div;

    // Per-pixel data that rides along with the division.
    typedef struct packed {
        logic [HUE_BITS-1:0]   offset;
        logic                  neg;
        logic                  grey;
        logic [LEVEL_BITS-1:0] level;
        logic [ALPHA_BITS-1:0] alpha;
    } t_side;

    function automatic t_div div_steps(t_div x, t_chan den);
        t_div                  y;
        logic [CHANNEL_BITS:0] t;
        logic [CHANNEL_BITS:0] diff;
        logic                  qbit;
        y = x;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            t    = {y.rem, y.num[DIV_W-1]};
            diff = t - {1'b0, den};
            qbit = (t >= {1'b0, den});
            if (qbit) begin
                y.rem = diff[CHANNEL_BITS-1:0];
            end else begin
                y.rem = t[CHANNEL_BITS-1:0];
            end
            y.num = {y.num[DIV_W-2:0], qbit};
        end
        return y;
    endfunction

endpackage

### src/rgb_to_hsv_hsl.sv
// Top level of the RGB to HSV/HSL converter: mode register and the pixel pipeline.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -----------------------------------------------
//  pixel in  start, busy               i_red, i_green, i_blue, i_alpha_in
//  result    o_valid (strobe)          o_hue_angle, o_saturation, o_level, o_alpha_out
//  config    i_cfg_valid, o_cfg_ready  i_cfg_data (output mode)
//
// One pixel is taken every cycle; each result appears in order after its start, having
// passed the front stage, the divider stages and the output stage. The divider stages form
// the hue and saturation quotients by long division, three quotient bits per stage.
// busy stays low and the result strobe cannot be held off, so nothing ever stalls.
// Reset clears the valid bits of every stage and sets the mode to HSV.
module rgb_to_hsv_hsl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  rhh_pkg::t_chan                  i_red,
    input  rhh_pkg::t_chan                  i_green,
    input  rhh_pkg::t_chan                  i_blue,
    input  logic [rhh_pkg::ALPHA_BITS-1:0]  i_alpha_in,
    output logic                            o_valid,
    output logic [rhh_pkg::HUE_BITS-1:0]    o_hue_angle,
    output logic [rhh_pkg::SAT_BITS-1:0]    o_saturation,
    output logic [rhh_pkg::LEVEL_BITS-1:0]  o_level,
    output logic [rhh_pkg::ALPHA_BITS-1:0]  o_alpha_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_data
);

    rhh_pkg::t_mode            r_mode;
    logic                      accept;

    logic                      f_valid;
    rhh_pkg::t_side            f_side;
    logic [rhh_pkg::DIV_W-1:0] f_hue_num, f_sat_num;
    rhh_pkg::t_chan            f_hue_den, f_sat_den;

    logic                      d_valid;
    rhh_pkg::t_side            d_side;
    rhh_pkg::t_div             d_hue, d_sat;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rhh_pkg::MODE_HSV;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= rhh_pkg::t_mode'(i_cfg_data);
        end
    end

    rhh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_mode    (r_mode),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .i_alpha   (i_alpha_in),
        .o_valid   (f_valid),
        .o_side    (f_side),
        .o_hue_num (f_hue_num),
        .o_hue_den (f_hue_den),
        .o_sat_num (f_sat_num),
        .o_sat_den (f_sat_den)
    );

    rhh_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (f_valid),
        .i_side    (f_side),
        .i_hue_num (f_hue_num),
        .i_hue_den (f_hue_den),
        .i_sat_num (f_sat_num),
        .i_sat_den (f_sat_den),
        .o_valid   (d_valid),
        .o_side    (d_side),
        .o_hue     (d_hue),
        .o_sat     (d_sat)
    );

    rhh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (d_valid),
        .i_side       (d_side),
        .i_hue        (d_hue),
        .i_sat        (d_sat),
        .o_valid      (o_valid),
        .o_hue_angle  (o_hue_angle),
        .o_saturation (o_saturation),
        .o_level      (o_level),
        .o_alpha      (o_alpha_out)
    );

    // Every accepted pixel comes out after the fixed pipeline length.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(rhh_pkg::LATENCY) o_valid)
        else $error("accepted pixel did not produce a result on time");

    a_hue_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue_angle < rhh_pkg::FULL_CIRCLE))
        else $error("hue outside one full circle");

    // Zero saturation only comes from a grey pixel, whose hue is zero too.
    a_grey : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturation == '0) |-> (o_hue_angle == '0))
        else $error("zero saturation with nonzero hue");

    a_hsv_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode == rhh_pkg::MODE_HSV) |-> (o_level[0] == 1'b0))
        else $error("HSV level is not twice the largest channel");

endmodule

### src/rhh_front.sv
// Front stage: channel extremes, hue sector, division operands and level.
module rhh_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rhh_pkg::t_mode                i_mode,
    input  rhh_pkg::t_chan                i_red,
    input  rhh_pkg::t_chan                i_green,
    input  rhh_pkg::t_chan                i_blue,
    input  logic [rhh_pkg::ALPHA_BITS-1:0] i_alpha,
    output logic                          o_valid,
    output rhh_pkg::t_side                o_side,
    output logic [rhh_pkg::DIV_W-1:0]     o_hue_num,
    output rhh_pkg::t_chan                o_hue_den,
    output logic [rhh_pkg::DIV_W-1:0]     o_sat_num,
    output rhh_pkg::t_chan                o_sat_den
);

    rhh_pkg::t_sector                    sector;
    rhh_pkg::t_chan                      mx, mn, chroma, op_a, op_b, delta, sat_den;
    logic [rhh_pkg::HUE_BITS-1:0]        offset;
    logic                                neg;
    logic [rhh_pkg::LEVEL_BITS-1:0]      sum, dev, level;

    logic                                r_valid;
    rhh_pkg::t_side                      r_side;
    logic [rhh_pkg::DIV_W-1:0]           r_hue_num, r_sat_num;
    rhh_pkg::t_chan                      r_hue_den, r_sat_den;

    always_comb begin
        // Ties go to green over red, and to red or green over blue: a channel wins only when strictly larger.
        if (i_red > i_green) begin
            sector = rhh_pkg::SEC_RED;
            mx     = i_red;
        end else begin
            sector = rhh_pkg::SEC_GREEN;
            mx     = i_green;
        end
        if (i_blue > mx) begin
            sector = rhh_pkg::SEC_BLUE;
            mx     = i_blue;
        end
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < mn) begin
            mn = i_blue;
        end
        chroma = mx - mn;

        case (sector)
            rhh_pkg::SEC_RED: begin
                op_a   = i_green;
                op_b   = i_blue;
                offset = (i_green >= i_blue) ? '0 : rhh_pkg::FULL_CIRCLE;
            end
            rhh_pkg::SEC_GREEN: begin
                op_a   = i_blue;
                op_b   = i_red;
                offset = rhh_pkg::GREEN_OFFSET;
            end
            rhh_pkg::SEC_BLUE: begin
                op_a   = i_red;
                op_b   = i_green;
                offset = rhh_pkg::BLUE_OFFSET;
            end
            default: begin
                op_a   = '0;
                op_b   = '0;
                offset = '0;
            end
        endcase
        neg   = (op_a < op_b);
        delta = neg ? (op_b - op_a) : (op_a - op_b);

        sum = {1'b0, mx} + {1'b0, mn};
        if (sum >= {1'b0, rhh_pkg::FULL_SCALE}) begin
            dev = sum - {1'b0, rhh_pkg::FULL_SCALE};
        end else begin
            dev = {1'b0, rhh_pkg::FULL_SCALE} - sum;
        end

        if (i_mode == rhh_pkg::MODE_HSL) begin
            sat_den = rhh_pkg::FULL_SCALE - dev[rhh_pkg::CHANNEL_BITS-1:0];
            level   = sum;
        end else begin
            sat_den = mx;
            level   = {mx, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side.offset <= offset;
        r_side.neg    <= neg;
        r_side.grey   <= (chroma == '0);
        r_side.level  <= level;
        r_side.alpha  <= i_alpha;
        r_hue_num     <= rhh_pkg::DIV_W'(delta) * rhh_pkg::DIV_W'(rhh_pkg::SECTOR_UNITS);
        r_hue_den     <= chroma;
        r_sat_num     <= rhh_pkg::DIV_W'(chroma) << rhh_pkg::SAT_FRAC;
        r_sat_den     <= sat_den;
    end

    assign o_valid   = r_valid;
    assign o_side    = r_side;
    assign o_hue_num = r_hue_num;
    assign o_hue_den = r_hue_den;
    assign o_sat_num = r_sat_num;
    assign o_sat_den = r_sat_den;

endmodule

### src/rhh_div.sv
// Pipelined restoring divider: two lanes (hue and saturation), a few quotient bits per stage.
module rhh_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  rhh_pkg::t_side            i_side,
    input  logic [rhh_pkg::DIV_W-1:0] i_hue_num,
    input  rhh_pkg::t_chan            i_hue_den,
    input  logic [rhh_pkg::DIV_W-1:0] i_sat_num,
    input  rhh_pkg::t_chan            i_sat_den,
    output logic                      o_valid,
    output rhh_pkg::t_side            o_side,
    output rhh_pkg::t_div             o_hue,
    output rhh_pkg::t_div             o_sat
);

    logic           r_valid [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_side r_side  [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_div  r_hue   [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_div  r_sat   [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_chan r_hden  [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_chan r_sden  [rhh_pkg::DIV_STAGES];

    logic           w_valid [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_side w_side  [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_div  w_hue   [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_div  w_sat   [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_chan w_hden  [rhh_pkg::DIV_STAGES];
    rhh_pkg::t_chan w_sden  [rhh_pkg::DIV_STAGES];

    for (genvar s = 0; s < rhh_pkg::DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign w_valid[s]   = i_valid;
            assign w_side[s]    = i_side;
            assign w_hue[s].rem = '0;
            assign w_hue[s].num = i_hue_num;
            assign w_sat[s].rem = '0;
            assign w_sat[s].num = i_sat_num;
            assign w_hden[s]    = i_hue_den;
            assign w_sden[s]    = i_sat_den;
        end else begin : g_next
            assign w_valid[s] = r_valid[s-1];
            assign w_side[s]  = r_side[s-1];
            assign w_hue[s]   = r_hue[s-1];
            assign w_sat[s]   = r_sat[s-1];
            assign w_hden[s]  = r_hden[s-1];
            assign w_sden[s]  = r_sden[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= w_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[s] <= w_side[s];
            r_hue[s]  <= rhh_pkg::div_steps(w_hue[s], w_hden[s]);
            r_sat[s]  <= rhh_pkg::div_steps(w_sat[s], w_sden[s]);
            r_hden[s] <= w_hden[s];
            r_sden[s] <= w_sden[s];
        end
    end

    assign o_valid = r_valid[rhh_pkg::DIV_STAGES-1];
    assign o_side  = r_side[rhh_pkg::DIV_STAGES-1];
    assign o_hue   = r_hue[rhh_pkg::DIV_STAGES-1];
    assign o_sat   = r_sat[rhh_pkg::DIV_STAGES-1];

endmodule

### src/rhh_back.sv
// Output stage: hue offset and rounding, saturation clamp, grey handling.
module rhh_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  rhh_pkg::t_side                  i_side,
    input  rhh_pkg::t_div                   i_hue,
    input  rhh_pkg::t_div                   i_sat,
    output logic                            o_valid,
    output logic [rhh_pkg::HUE_BITS-1:0]    o_hue_angle,
    output logic [rhh_pkg::SAT_BITS-1:0]    o_saturation,
    output logic [rhh_pkg::LEVEL_BITS-1:0]  o_level,
    output logic [rhh_pkg::ALPHA_BITS-1:0]  o_alpha
);

    logic [rhh_pkg::HUE_BITS-1:0]   quo, n_hue;
    logic [rhh_pkg::SAT_BITS-1:0]   n_sat;
    logic                           r_valid;
    logic [rhh_pkg::HUE_BITS-1:0]   r_hue;
    logic [rhh_pkg::SAT_BITS-1:0]   r_sat;
    logic [rhh_pkg::LEVEL_BITS-1:0] r_level;
    logic [rhh_pkg::ALPHA_BITS-1:0] r_alpha;

    always_comb begin
        quo = i_hue.num[rhh_pkg::HUE_BITS-1:0];
        // A negative sector term is truncated toward zero, so it is subtracted rounded up.
        if (i_side.neg) begin
            n_hue = i_side.offset - quo - rhh_pkg::HUE_BITS'(i_hue.rem != '0);
        end else begin
            n_hue = i_side.offset + quo;
        end
        if (i_sat.num[rhh_pkg::DIV_W-1:rhh_pkg::SAT_BITS] != '0) begin
            n_sat = '1;
        end else begin
            n_sat = i_sat.num[rhh_pkg::SAT_BITS-1:0];
        end
        if (i_side.grey) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue   <= n_hue;
        r_sat   <= n_sat;
        r_level <= i_side.level;
        r_alpha <= i_side.alpha;
    end

    assign o_valid      = r_valid;
    assign o_hue_angle  = r_hue;
    assign o_saturation = r_sat;
    assign o_level      = r_level;
    assign o_alpha      = r_alpha;

endmodule

### tb/testbench.sv
// Self-checking testbench for the RGB to HSV/HSL pixel converter.
`timescale 1ns / 1ps

typedef struct packed {
    logic [rhh_pkg::HUE_BITS-1:0]   hue;
    logic [rhh_pkg::SAT_BITS-1:0]   sat;
    logic [rhh_pkg::LEVEL_BITS-1:0] level;
    logic [rhh_pkg::ALPHA_BITS-1:0] alpha;
} t_pixel_result;

class pixel_scoreboard;
    rhh_pkg::t_mode mode;
    t_pixel_result  expected_q[$];
    int             mismatches;
    int             checked;

    function new();
        mode       = rhh_pkg::MODE_HSV;
        mismatches = 0;
        checked    = 0;
    endfunction

    // Offset plus the sector fraction, rounded down: a negative term is subtracted rounded up.
    static function int sector_angle(int offset, int a, int b, int c);
        if (a >= b) begin
            return offset + (3840 * (a - b)) / c;
        end
        return offset - (3840 * (b - a) + c - 1) / c;
    endfunction

    function t_pixel_result convert_pixel(rhh_pkg::t_chan r, rhh_pkg::t_chan g,
                                          rhh_pkg::t_chan b, logic [7:0] a);
        t_pixel_result res;
        int        ch[3];
        int        hi;
        int        lo;
        int        mx;
        int        mn;
        int        c;
        int        hue;
        int        sat;
        int        lvl;
        int        sum;
        int        dev;
        ch[0] = r;
        ch[1] = g;
        ch[2] = b;
        hi = (ch[0] > ch[1]) ? 0 : 1;
        if (ch[2] > ch[hi]) begin
            hi = 2;
        end
        lo = (ch[0] < ch[1]) ? 0 : 1;
        if (ch[2] < ch[lo]) begin
            lo = 2;
        end
        mx  = ch[hi];
        mn  = ch[lo];
        c   = mx - mn;
        hue = 0;
        sat = 0;
        if (c != 0) begin
            case (hi)
                0: hue = (ch[1] >= ch[2]) ? sector_angle(0, ch[1], ch[2], c)
                                          : sector_angle(23040, ch[1], ch[2], c);
                1: hue = sector_angle(7680, ch[2], ch[0], c);
                default: hue = sector_angle(15360, ch[0], ch[1], c);
            endcase
        end
        if (mode == rhh_pkg::MODE_HSV) begin
            lvl = 2 * mx;
            if (c != 0) begin
                sat = (c << 16) / mx;
            end
        end else begin
            sum = mn + mx;
            dev = (sum >= 255) ? sum - 255 : 255 - sum;
            lvl = sum;
            if (c != 0) begin
                sat = (c << 16) / (255 - dev);
            end
        end
        if (sat > 65535) begin
            sat = 65535;
        end
        res.hue   = hue[rhh_pkg::HUE_BITS-1:0];
        res.sat   = sat[rhh_pkg::SAT_BITS-1:0];
        res.level = lvl[rhh_pkg::LEVEL_BITS-1:0];
        res.alpha = a;
        return res;
    endfunction

    function void note_pixel(rhh_pkg::t_chan r, rhh_pkg::t_chan g,
                             rhh_pkg::t_chan b, logic [7:0] a);
        expected_q.push_back(convert_pixel(r, g, b, a));
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(string what, int got, int want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task check_result(t_pixel_result got);
        t_pixel_result want;
        if (expected_q.size() == 0) begin
            report("result with no pixel outstanding", got.hue, -1);
        end else begin
            want = expected_q.pop_front();
            checked++;
            if (got.hue !== want.hue) begin
                report("hue_angle", got.hue, want.hue);
            end
            if (got.sat !== want.sat) begin
                report("saturation", got.sat, want.sat);
            end
            if (got.level !== want.level) begin
                report("level", got.level, want.level);
            end
            if (got.alpha !== want.alpha) begin
                report("alpha_out", got.alpha, want.alpha);
            end
        end
    endtask
endclass

module testbench;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    rhh_pkg::t_chan                 i_red;
    rhh_pkg::t_chan                 i_green;
    rhh_pkg::t_chan                 i_blue;
    logic [rhh_pkg::ALPHA_BITS-1:0] i_alpha_in;
    logic                           o_valid;
    logic [rhh_pkg::HUE_BITS-1:0]   o_hue_angle;
    logic [rhh_pkg::SAT_BITS-1:0]   o_saturation;
    logic [rhh_pkg::LEVEL_BITS-1:0] o_level;
    logic [rhh_pkg::ALPHA_BITS-1:0] o_alpha_out;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic                           i_cfg_data;

    pixel_scoreboard sb;
    bit              idle_on;
    int              pixels_sent;
    int              mode_writes;

    rgb_to_hsv_hsl dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_alpha_in   (i_alpha_in),
        .o_valid      (o_valid),
        .o_hue_angle  (o_hue_angle),
        .o_saturation (o_saturation),
        .o_level      (o_level),
        .o_alpha_out  (o_alpha_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    // Every handshake is observed here on the values held just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.mode = rhh_pkg::t_mode'(i_cfg_data);
            end
            if (start && !busy) begin
                sb.note_pixel(i_red, i_green, i_blue, i_alpha_in);
            end
            if (o_valid) begin
                sb.check_result({o_hue_angle, o_saturation, o_level, o_alpha_out});
            end
        end
    end

    task automatic send_pixel(input rhh_pkg::t_chan r, input rhh_pkg::t_chan g,
                              input rhh_pkg::t_chan b, input logic [7:0] a);
        // When idle_on is set, each cycle before the transaction is left idle with a fixed chance.
        while (idle_on && $urandom_range(99) < 29) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        i_alpha_in <= a;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pixels_sent++;
    endtask

    // Stops the sender and lets the pipeline run empty.
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (rhh_pkg::LATENCY) @(posedge i_clk);
    endtask

    task automatic write_mode(input rhh_pkg::t_mode m);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    initial begin
        #200000;
        $display("rgb_to_hsv_hsl test failed");
        $finish;
    end

    initial begin
        logic [31:0]    corner[12];
        rhh_pkg::t_chan r;
        rhh_pkg::t_chan g;
        rhh_pkg::t_chan b;
        int             kind;
        rhh_pkg::t_mode m;

        sb          = new();
        idle_on     = 1'b0;
        pixels_sent = 0;
        mode_writes = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_alpha_in  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;

        // Grey levels, primaries, tied maxima, the negative wrap of the red
        // sector and the clamped full-saturation ratio.
        corner[0]  = {8'd0,   8'd0,   8'd0,   8'd0};
        corner[1]  = {8'd255, 8'd255, 8'd255, 8'd255};
        corner[2]  = {8'd128, 8'd128, 8'd128, 8'd77};
        corner[3]  = {8'd255, 8'd0,   8'd0,   8'd255};
        corner[4]  = {8'd0,   8'd255, 8'd0,   8'd1};
        corner[5]  = {8'd0,   8'd0,   8'd255, 8'd128};
        corner[6]  = {8'd255, 8'd255, 8'd0,   8'd170};
        corner[7]  = {8'd0,   8'd255, 8'd255, 8'd85};
        corner[8]  = {8'd255, 8'd0,   8'd255, 8'd254};
        corner[9]  = {8'd255, 8'd0,   8'd1,   8'd3};
        corner[10] = {8'd1,   8'd0,   8'd0,   8'd200};
        corner[11] = {8'd200, 8'd100, 8'd50,  8'd64};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 2; p++) begin
            if (p == 0) begin
                m = rhh_pkg::MODE_HSV;
            end else begin
                m = rhh_pkg::MODE_HSL;
            end
            write_mode(m);
            foreach (corner[k]) begin
                send_pixel(corner[k][31:24], corner[k][23:16], corner[k][15:8],
                           corner[k][7:0]);
            end
        end

        // Random phases alternate the mode; the third runs back to back.
        for (int ph = 0; ph < 4; ph++) begin
            if (ph % 2 == 0) begin
                m = rhh_pkg::MODE_HSL;
            end else begin
                m = rhh_pkg::MODE_HSV;
            end
            write_mode(m);
            idle_on = (ph != 2);
            for (int n = 0; n < 170; n++) begin
                if (ph == 1 && n == 60) begin
                    drain_pipeline();
                end
                r    = 8'($urandom_range(255));
                g    = 8'($urandom_range(255));
                b    = 8'($urandom_range(255));
                kind = int'($urandom_range(99));
                if (kind < 8) begin
                    g = r;
                    b = r;
                end else if (kind < 18) begin
                    case ($urandom_range(2))
                        0: g = r;
                        1: b = g;
                        default: b = r;
                    endcase
                end else if (kind < 28) begin
                    r = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
                    if ($urandom_range(1) != 0) begin
                        g = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
                    end
                    if ($urandom_range(1) != 0) begin
                        b = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
                    end
                end
                send_pixel(r, g, b, 8'($urandom_range(255)));
            end
        end

        drain_pipeline();
        repeat (2 * rhh_pkg::LATENCY) @(posedge i_clk);
        while (sb.pending() != 0) begin
            sb.report("pixel with no result", sb.pending(), 0);
            void'(sb.expected_q.pop_front());
        end

        $display("Sent %0d pixels over %0d mode writes, HSV and HSL alternating.",
                 pixels_sent, mode_writes);
        $display("Checked %0d results, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("rgb_to_hsv_hsl test passed");
        end else begin
            $display("rgb_to_hsv_hsl test failed");
        end
        $finish;
    end
endmodule

### rgb_to_hsv_hsl.f
src/rhh_pkg.sv
src/rhh_front.sv
src/rhh_div.sv
src/rhh_back.sv
src/rgb_to_hsv_hsl.sv
tb/testbench.sv
